// File: design/hrhc_pkg.sv
`timescale 1ns / 1ps
package hrhc_pkg;

    // Bytes of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_H     = 8'h48;

    localparam logic [3:0] COL_MAX     = 4'd15;
    localparam logic [2:0] WORDS_MAX   = 3'd4;
    localparam logic [2:0] WORDS_REQ   = 3'd3;
    localparam logic [2:0] WORDS_HOST  = 3'd2;
    localparam logic [3:0] GET_LEN     = 4'd4;
    localparam logic [3:0] ROOT_LEN    = 4'd6;
    localparam logic [3:0] HOST_LEN    = 4'd6;

    // Marker tracker: 0..4 chars of "HTTP/" matched, then version digits
    localparam logic [3:0] MK_SLASH    = 4'd5;
    localparam logic [3:0] MK_ONE      = 4'd6;
    localparam logic [3:0] MK_DOT      = 4'd7;
    localparam logic [3:0] MK_DONE     = 4'd8;

    localparam logic [1:0] PH_NONE     = 2'd0;
    localparam logic [1:0] PH_REQ      = 2'd1;
    localparam logic [1:0] PH_HOST     = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_REQ   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0] phase;
        logic       bad_path;
        logic [3:0] column;
        logic       get_ok;
        logic       root_ok;
        logic       host_ok;
        logic [2:0] word_total;
        logic       inside_word;
        logic [3:0] marker;
        logic       version_ok;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } t_scan_res;

    // "GET / " (the first four bytes are also "GET ")
    function automatic logic [7:0] f_root_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h47; // G
            3'd1:    c = 8'h45; // E
            3'd2:    c = 8'h54; // T
            3'd3:    c = 8'h20;
            3'd4:    c = 8'h2F; // /
            3'd5:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Host: "
    function automatic logic [7:0] f_host_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48; // H
            3'd1:    c = 8'h6F; // o
            3'd2:    c = 8'h73; // s
            3'd3:    c = 8'h74; // t
            3'd4:    c = 8'h3A; // :
            3'd5:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "HTTP/"
    function automatic logic [7:0] f_mark_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48; // H
            3'd1:    c = 8'h54; // T
            3'd2:    c = 8'h54; // T
            3'd3:    c = 8'h50; // P
            3'd4:    c = 8'h2F; // /
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic t_state f_line_clear(input t_state s);
        t_state r;
        r             = s;
        r.column      = '0;
        r.get_ok      = 1'b1;
        r.root_ok     = 1'b1;
        r.host_ok     = 1'b1;
        r.word_total  = '0;
        r.inside_word = 1'b0;
        r.marker      = '0;
        r.version_ok  = 1'b0;
        return r;
    endfunction

    function automatic t_state f_reset_state();
        t_state r;
        r          = '0;
        r          = f_line_clear(r);
        r.phase    = PH_NONE;
        r.bad_path = 1'b0;
        return r;
    endfunction

endpackage

// File: design/hrhc_line_scan.sv
`timescale 1ns / 1ps
module hrhc_line_scan (
    input  hrhc_pkg::t_state    i_state,
    input  logic [7:0]          i_byte,
    output hrhc_pkg::t_state    o_state,
    output hrhc_pkg::t_scan_res o_res
);
    import hrhc_pkg::*;

    logic   is_lf;
    logic   is_sep;
    logic   hdr_end;
    logic   get_line;
    logic   host_line;
    t_state s;

    assign is_lf   = (i_byte == CH_LF);
    assign is_sep  = (i_byte == CH_SPACE) || (i_byte == CH_TAB) || is_lf ||
                     (i_byte == CH_CR) || (i_byte == CH_NUL);
    assign hdr_end = is_lf && (i_state.column == '0);

    always_comb begin
        s = i_state;

        if (i_state.column < GET_LEN && i_byte != f_root_char(i_state.column[2:0]))
            s.get_ok = 1'b0;
        if (i_state.column < ROOT_LEN && i_byte != f_root_char(i_state.column[2:0]))
            s.root_ok = 1'b0;
        if (i_state.column < HOST_LEN && i_byte != f_host_char(i_state.column[2:0]))
            s.host_ok = 1'b0;

        if (is_sep) begin
            if (i_state.inside_word) begin
                s.inside_word = 1'b0;
                if (i_state.word_total < WORDS_MAX)
                    s.word_total = i_state.word_total + 3'd1;
            end
        end else begin
            s.inside_word = 1'b1;
        end

        // only the first "HTTP/" in a line decides the version
        if (i_state.marker < MK_SLASH) begin
            if (i_byte == f_mark_char(i_state.marker[2:0]))
                s.marker = i_state.marker + 4'd1;
            else
                s.marker = (i_byte == CH_H) ? 4'd1 : 4'd0;
        end else if (i_state.marker == MK_SLASH) begin
            s.marker = (i_byte == CH_ONE) ? MK_ONE : MK_DONE;
        end else if (i_state.marker == MK_ONE) begin
            s.marker = (i_byte == CH_DOT) ? MK_DOT : MK_DONE;
        end else if (i_state.marker == MK_DOT) begin
            s.version_ok = (i_byte == CH_ZERO) || (i_byte == CH_ONE);
            s.marker     = MK_DONE;
        end else begin
            s.marker = MK_DONE;
        end

        if (i_state.column < COL_MAX)
            s.column = i_state.column + 4'd1;

        get_line  = s.get_ok && (s.word_total == WORDS_REQ) && s.version_ok;
        host_line = s.host_ok && (s.word_total == WORDS_HOST);

        if (is_lf) begin
            if (i_state.phase == PH_NONE && get_line) begin
                s.phase    = PH_REQ;
                s.bad_path = !s.root_ok;
            end else if (i_state.phase == PH_REQ && host_line) begin
                s.phase = PH_HOST;
            end
            s = f_line_clear(s);
        end

        o_res.valid = hdr_end;
        if (i_state.phase != PH_HOST)
            o_res.status = ST_BAD_REQ;
        else if (i_state.bad_path)
            o_res.status = ST_NOT_FOUND;
        else
            o_res.status = ST_OK;

        o_state = hdr_end ? f_reset_state() : s;
    end

endmodule

// File: design/http_request_header_check.sv
`timescale 1ns / 1ps
// Checks an HTTP request header streamed in one byte per item. LF ends a
// line (CR is an ordinary byte) and an empty line ends the header, at which
// point one status item is sent: 0 = 200, 1 = 400 (no valid "GET" request
// line or no Host line after it), 2 = 404 (path is not "/"); the checker
// then starts afresh. Sustained rate is one byte per clock: each byte is
// captured in an input register and the line scanner updates the whole
// parse state from it in a single pass. The status is held in an output
// register, loaded when the blank line's LF leaves the input register;
// input stalls only when a status is ready to be produced while the
// previous one is still waiting to be taken.
module http_request_header_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [1:0] status, [7:2] zero
);
    import hrhc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    logic       r_out_valid;
    logic [1:0] r_out_status;

    t_state     n_state;
    t_scan_res  scan_res;
    logic       out_free;
    logic       advance;

    hrhc_line_scan u_scan (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (n_state),
        .o_res   (scan_res)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (!scan_res.valid || out_free);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= f_reset_state();
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready)
                r_in_valid <= i_s_tvalid;
            if (advance)
                r_state <= n_state;
            if (advance && scan_res.valid)
                r_out_valid <= 1'b1;
            else if (i_m_tready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid)
            r_in_byte <= i_s_tdata;
        if (advance && scan_res.valid)
            r_out_status <= scan_res.status;
    end

    // a status never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && scan_res.valid && r_out_valid && !i_m_tready) |-> !advance)
        else $error("status produced while output register busy");

    // end of header leaves a fresh parse state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && scan_res.valid) |=>
            (r_state.phase == PH_NONE && r_state.column == 4'd0 && !r_state.bad_path))
        else $error("state not cleared after header end");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != 2'd3) && (r_state.word_total <= WORDS_MAX) &&
        (r_state.marker <= MK_DONE))
        else $error("parse state out of range");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out_status == ST_OK || r_out_status == ST_BAD_REQ ||
                        r_out_status == ST_NOT_FOUND))
        else $error("illegal status code");

endmodule
